[sv/montgomery_modular_alu_core_assert.svh]
// assertion macros for the montgomery alu checker
`ifndef MONTGOMERY_MODULAR_ALU_CORE_ASSERT_SVH
`define MONTGOMERY_MODULAR_ALU_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mma_pkg.sv]
// shared types and constants of the montgomery modular alu
`timescale 1ns / 1ps

package mma_pkg;

    localparam int MMA_WORD_BITS = 32;
    localparam int MMA_MOD_BITS  = 30;
    localparam int MMA_RES_BITS  = 31;
    localparam int MMA_DIV_BITS  = 64;
    localparam logic [MMA_MOD_BITS-1:0] MMA_RESET_MODULUS = 30'd998244353;

    typedef enum logic [2:0] {
        CMD_TO_MONT   = 3'd0,
        CMD_FROM_MONT = 3'd1,
        CMD_ADD       = 3'd2,
        CMD_SUB       = 3'd3,
        CMD_MUL       = 3'd4,
        CMD_POW       = 3'd5,
        CMD_INV       = 3'd6,
        CMD_EQUAL     = 3'd7
    } t_mma_cmd;

    typedef struct packed {
        t_mma_cmd                 cmd;
        logic [MMA_RES_BITS-1:0]  op_a;
        logic [MMA_RES_BITS-1:0]  op_b;
        logic signed [63:0]       exponent;
        logic signed [63:0]       plain_value;
    } t_mma_in;

    typedef struct packed {
        logic [MMA_RES_BITS-1:0]  result;
        logic                     is_equal;
    } t_mma_out;

endpackage

[sv/mma_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mma_div
    import mma_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [MMA_DIV_BITS-1:0] i_dividend,
    input  logic [MMA_RES_BITS-1:0] i_divisor,
    output logic                    o_done,
    output logic [MMA_DIV_BITS-1:0] o_quotient,
    output logic [MMA_RES_BITS-1:0] o_remainder
);

    localparam int CNT_W = $clog2(MMA_DIV_BITS + 1);

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic [MMA_RES_BITS-1:0] r_rem;
    logic [MMA_DIV_BITS-1:0] r_quo;
    logic [MMA_RES_BITS-1:0] r_div;
    logic [MMA_RES_BITS:0]   trial;
    logic                    fits;

    // shift in next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[MMA_DIV_BITS-1]};
    assign fits  = trial >= {1'b0, r_div};

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(MMA_DIV_BITS);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= fits ? MMA_RES_BITS'(trial - {1'b0, r_div})
                              : trial[MMA_RES_BITS-1:0];
                r_quo <= {r_quo[MMA_DIV_BITS-2:0], fits};
            end
        end
    end

endmodule

[sv/mma_redc.sv]
// bit-serial montgomery reduction, one bit of R per cycle
`timescale 1ns / 1ps

module mma_redc
    import mma_pkg::*;
#(
    parameter int WORD_BITS = MMA_WORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [63:0]             i_value,
    input  logic [MMA_MOD_BITS-1:0] i_mod,
    output logic                    o_done,
    output logic [63:0]             o_value
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_acc;
    logic [64:0]      sum;

    // add m when odd so the low bit clears, then halve
    assign sum = {1'b0, r_acc} + (r_acc[0] ? {35'd0, i_mod} : 65'd0);

    assign o_done  = r_busy && (r_cnt == '0);
    assign o_value = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(WORD_BITS);
            r_acc  <= i_value;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                r_acc <= sum[64:1];
            end
        end
    end

endmodule

[sv/montgomery_modular_alu_core.sv]
// montgomery alu top level: sequencer, shared multiplier and output register
// add, sub and equal finish in the sequencer; mul and from_mont pass through the reduction unit
// to_mont first waits on the bit-per-cycle divider, then goes through the reduction unit
// pow runs up to a multiply and a square per exponent bit through the shared reduction unit
// inv and negative pow run euclid steps on the divider; one item at a time
// after reset and after each modulus write, not ready while R^2 mod m is derived
`timescale 1ns / 1ps

module montgomery_modular_alu_core
    import mma_pkg::*;
#(
    parameter int WORD_BITS = MMA_WORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [MMA_MOD_BITS-1:0] i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_mma_in                 i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_mma_out                o_out
);

    localparam int DCNT_W = $clog2(2 * WORD_BITS + 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DERIVE  = 10'b00_0000_0010,
        S_TM_DIV  = 10'b00_0000_0100,
        S_MUL     = 10'b00_0000_1000,
        S_RED     = 10'b00_0001_0000,
        S_PW_LOOP = 10'b00_0010_0000,
        S_INV_CHK = 10'b00_0100_0000,
        S_INV_DIV = 10'b00_1000_0000,
        S_INV_UPD = 10'b01_0000_0000,
        S_FINISH  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        RET_TM,
        RET_MUL,
        RET_PV,
        RET_PW_MUL,
        RET_PW_SQ,
        RET_EUC
    } t_ret;

    t_state                  r_state;
    t_ret                    r_ret;
    t_mma_cmd                r_cmd;
    logic [MMA_MOD_BITS-1:0] r_mod;
    logic [MMA_MOD_BITS-1:0] r_r2;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [MMA_RES_BITS-1:0] r_res;
    logic                    r_eq;
    logic [MMA_RES_BITS-1:0] r_base;
    logic [63:0]             r_e;
    logic                    r_e_neg;
    logic                    r_tm_neg;
    logic                    r_tm_pow;
    logic signed [33:0]      r_mx;
    logic signed [31:0]      r_my;
    logic [MMA_RES_BITS-1:0] r_x;
    logic [MMA_RES_BITS-1:0] r_y;
    logic [MMA_RES_BITS-1:0] r_rem;
    logic signed [33:0]      r_u;
    logic signed [33:0]      r_v;
    logic signed [33:0]      r_prod;
    logic                    r_out_valid;
    logic [MMA_RES_BITS-1:0] r_out_res;
    logic                    r_out_eq;

    logic [MMA_MOD_BITS-1:0] m;
    logic [MMA_RES_BITS-1:0] m2;
    logic                    accept;
    logic [63:0]             pv_mag;
    logic [63:0]             exp_mag;
    logic [31:0]             add_sum;
    logic [MMA_RES_BITS-1:0] add_res;
    logic [31:0]             sub_wide;
    logic [MMA_RES_BITS-1:0] sub_res;
    logic [MMA_RES_BITS-1:0] eq_ra;
    logic [MMA_RES_BITS-1:0] eq_rb;
    logic [MMA_RES_BITS-1:0] d_shift;
    logic [MMA_MOD_BITS-1:0] d_next;
    logic [33:0]             u_mag;
    logic [MMA_RES_BITS-1:0] tm_base;
    logic [MMA_RES_BITS-1:0] pv_val;
    logic [MMA_RES_BITS-1:0] red31;
    logic signed [65:0]      mul_p;

    logic                    div_start;
    logic [MMA_DIV_BITS-1:0] div_dividend;
    logic [MMA_RES_BITS-1:0] div_divisor;
    logic                    div_done;
    logic [MMA_DIV_BITS-1:0] div_quo;
    logic [MMA_RES_BITS-1:0] div_rem;
    logic                    redc_start;
    logic                    redc_done;
    logic [63:0]             redc_val;

    // modulus is always odd
    assign m  = {r_mod[MMA_MOD_BITS-1:1], 1'b1};
    assign m2 = {m, 1'b0};

    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out.result = r_out_res;
    assign o_out.is_equal = r_out_eq;

    // magnitudes of the signed inputs
    assign pv_mag  = i_in.plain_value[63] ? (~i_in.plain_value + 64'd1) : i_in.plain_value;
    assign exp_mag = i_in.exponent[63] ? (~i_in.exponent + 64'd1) : i_in.exponent;

    // combinational results of add, sub and equal
    assign add_sum  = {1'b0, i_in.op_a} + {1'b0, i_in.op_b};
    assign add_res  = (add_sum >= {1'b0, m2}) ? MMA_RES_BITS'(add_sum - {1'b0, m2})
                                              : add_sum[MMA_RES_BITS-1:0];
    assign sub_wide = {1'b0, i_in.op_a} + {1'b0, m2} - {1'b0, i_in.op_b};
    assign sub_res  = (i_in.op_a >= i_in.op_b) ? (i_in.op_a - i_in.op_b)
                                               : sub_wide[MMA_RES_BITS-1:0];
    assign eq_ra    = (i_in.op_a >= {1'b0, m}) ? (i_in.op_a - {1'b0, m}) : i_in.op_a;
    assign eq_rb    = (i_in.op_b >= {1'b0, m}) ? (i_in.op_b - {1'b0, m}) : i_in.op_b;

    // doubling step of the R^2 mod m derivation
    assign d_shift = {r_r2, 1'b0};
    assign d_next  = (d_shift >= {1'b0, m}) ? MMA_MOD_BITS'(d_shift - {1'b0, m})
                                            : d_shift[MMA_MOD_BITS-1:0];

    // to_mont base from the remainder, euclid coefficient magnitude
    assign u_mag   = r_u[33] ? 34'(-r_u) : 34'(r_u);
    assign tm_base = r_tm_neg ? ({1'b0, m} - div_rem) : (div_rem + {1'b0, m});

    // reduction results
    assign red31  = redc_val[MMA_RES_BITS-1:0];
    assign pv_val = (redc_val >= {34'd0, m}) ? MMA_RES_BITS'(redc_val - {34'd0, m}) : red31;

    // shared multiplier
    assign mul_p = r_mx * r_my;

    // divider launch
    always_comb begin
        div_start    = 1'b0;
        div_dividend = pv_mag;
        div_divisor  = {1'b0, m};
        if (r_state == S_INV_CHK) begin
            div_start = 1'b1;
            if (r_y == '0) begin
                div_dividend = {30'd0, u_mag};
            end else begin
                div_dividend = {33'd0, r_x};
                div_divisor  = r_y;
            end
        end else if (accept && (i_in.cmd == CMD_TO_MONT || i_in.cmd == CMD_POW)) begin
            div_start = 1'b1;
            if (i_in.cmd == CMD_POW) begin
                div_dividend = 64'd1;
            end
        end
    end

    assign redc_start = (r_state == S_MUL) && (r_ret != RET_EUC);

    mma_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    mma_redc #(.WORD_BITS(WORD_BITS)) u_redc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (redc_start),
        .i_value (mul_p[63:0]),
        .i_mod   (m),
        .o_done  (redc_done),
        .o_value (redc_val)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DERIVE;
            r_mod       <= MMA_RESET_MODULUS;
            r_r2        <= MMA_MOD_BITS'(1);
            r_dcnt      <= DCNT_W'(2 * WORD_BITS);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_mod   <= i_cfg_wdata;
                r_r2    <= (i_cfg_wdata[MMA_MOD_BITS-1:1] == '0) ? '0 : MMA_MOD_BITS'(1);
                r_dcnt  <= DCNT_W'(2 * WORD_BITS);
                r_state <= S_DERIVE;
            end else begin
                unique case (r_state)
                    S_DERIVE: begin
                        if (r_dcnt == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_r2   <= d_next;
                            r_dcnt <= r_dcnt - 1'b1;
                        end
                    end
                    S_IDLE: begin
                        if (accept) begin
                            r_cmd    <= i_in.cmd;
                            r_eq     <= 1'b0;
                            r_base   <= i_in.op_a;
                            r_e      <= exp_mag;
                            r_e_neg  <= i_in.exponent[63];
                            r_tm_pow <= 1'b0;
                            unique case (i_in.cmd)
                                CMD_TO_MONT: begin
                                    r_tm_neg <= i_in.plain_value[63];
                                    r_state  <= S_TM_DIV;
                                end
                                CMD_FROM_MONT, CMD_INV: begin
                                    r_mx    <= {3'd0, i_in.op_a};
                                    r_my    <= 32'sd1;
                                    r_ret   <= RET_PV;
                                    r_state <= S_MUL;
                                end
                                CMD_ADD: begin
                                    r_res   <= add_res;
                                    r_state <= S_FINISH;
                                end
                                CMD_SUB: begin
                                    r_res   <= sub_res;
                                    r_state <= S_FINISH;
                                end
                                CMD_MUL: begin
                                    r_mx    <= {3'd0, i_in.op_a};
                                    r_my    <= {1'b0, i_in.op_b};
                                    r_ret   <= RET_MUL;
                                    r_state <= S_MUL;
                                end
                                CMD_POW: begin
                                    r_tm_neg <= 1'b0;
                                    r_tm_pow <= 1'b1;
                                    r_state  <= S_TM_DIV;
                                end
                                default: begin
                                    r_res   <= '0;
                                    r_eq    <= (eq_ra == eq_rb);
                                    r_state <= S_FINISH;
                                end
                            endcase
                        end
                    end
                    S_TM_DIV: begin
                        if (div_done) begin
                            r_mx    <= {3'd0, tm_base};
                            r_my    <= {2'd0, r_r2};
                            r_ret   <= RET_TM;
                            r_state <= S_MUL;
                        end
                    end
                    S_MUL: begin
                        if (r_ret == RET_EUC) begin
                            r_prod  <= mul_p[33:0];
                            r_state <= S_INV_UPD;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                    S_RED: begin
                        if (redc_done) begin
                            case (r_ret)
                                RET_PV: begin
                                    if (r_cmd == CMD_FROM_MONT) begin
                                        r_res   <= pv_val;
                                        r_state <= S_FINISH;
                                    end else begin
                                        r_x     <= pv_val;
                                        r_y     <= {1'b0, m};
                                        r_u     <= 34'sd1;
                                        r_v     <= '0;
                                        r_state <= S_INV_CHK;
                                    end
                                end
                                RET_TM: begin
                                    r_res   <= red31;
                                    r_state <= r_tm_pow ? S_PW_LOOP : S_FINISH;
                                end
                                RET_PW_MUL: begin
                                    r_res   <= red31;
                                    r_mx    <= {3'd0, r_base};
                                    r_my    <= {1'b0, r_base};
                                    r_ret   <= RET_PW_SQ;
                                    r_state <= S_MUL;
                                end
                                RET_PW_SQ: begin
                                    r_base  <= red31;
                                    r_e     <= {1'b0, r_e[63:1]};
                                    r_state <= S_PW_LOOP;
                                end
                                default: begin
                                    r_res   <= red31;
                                    r_state <= S_FINISH;
                                end
                            endcase
                        end
                    end
                    S_PW_LOOP: begin
                        if (r_e == '0) begin
                            r_tm_pow <= 1'b0;
                            if (r_e_neg) begin
                                r_mx    <= {3'd0, r_res};
                                r_my    <= 32'sd1;
                                r_ret   <= RET_PV;
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end else if (r_e[0]) begin
                            r_mx    <= {3'd0, r_res};
                            r_my    <= {1'b0, r_base};
                            r_ret   <= RET_PW_MUL;
                            r_state <= S_MUL;
                        end else begin
                            r_mx    <= {3'd0, r_base};
                            r_my    <= {1'b0, r_base};
                            r_ret   <= RET_PW_SQ;
                            r_state <= S_MUL;
                        end
                    end
                    S_INV_CHK: begin
                        // divider was launched either for q or for the final to_mont
                        if (r_y == '0) begin
                            r_tm_neg <= r_u[33];
                            r_state  <= S_TM_DIV;
                        end else begin
                            r_state <= S_INV_DIV;
                        end
                    end
                    S_INV_DIV: begin
                        if (div_done) begin
                            r_rem   <= div_rem;
                            r_mx    <= r_v;
                            r_my    <= {1'b0, div_quo[MMA_RES_BITS-1:0]};
                            r_ret   <= RET_EUC;
                            r_state <= S_MUL;
                        end
                    end
                    S_INV_UPD: begin
                        r_x     <= r_y;
                        r_y     <= r_rem;
                        r_u     <= r_v;
                        r_v     <= r_u - r_prod;
                        r_state <= S_INV_CHK;
                    end
                    S_FINISH: begin
                        if (!r_out_valid || i_out_ready) begin
                            r_out_valid <= 1'b1;
                            r_out_res   <= r_res;
                            r_out_eq    <= r_eq;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

[sv/mma_checker.sv]
// port-level checker for the montgomery alu, bound to the top level
`timescale 1ns / 1ps
`include "montgomery_modular_alu_core_assert.svh"

module mma_checker
    import mma_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input t_mma_out                o_out
);

    // a result beat holds until taken
    `MMA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped")

    // one item at a time
    `MMA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")

    // modulus write starts the derivation
    `MMA_ASSERT_NEXT(a_busy_after_cfg, i_cfg_we, !o_in_ready, "ready during derivation")

    // derivation after reset
    `MMA_ASSERT_SAME(a_busy_after_rst, $past(!i_rst_n), !o_in_ready, "ready right after reset")

    // equality beats carry a zero result
    `MMA_ASSERT_SAME(a_eq_zero, o_out_valid && o_out.is_equal, o_out.result == '0, "equal nonzero")

endmodule

bind montgomery_modular_alu_core mma_checker u_mma_checker (.*);

[tb/sv/tb.sv]
// self-checking testbench for the montgomery modular alu core
`timescale 1ns / 1ps

module tb;
    import mma_pkg::*;

    localparam int RED_STEPS  = MMA_WORD_BITS;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_WAIT = 200;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_LEN  = 80;
    localparam logic [30:0] MASK31 = 31'h7fffffff;

    // expected results and a bit-exact model of the alu
    class mont_scoreboard;
        t_mma_out    pending[$];
        bit   [63:0] modulus;
        bit   [63:0] r_sq;
        int          mismatches;
        int          checked;

        function new();
            set_modulus(MMA_RESET_MODULUS);
        endfunction

        function void set_modulus(logic [MMA_MOD_BITS-1:0] value);
            bit [63:0] r;
            modulus = {34'd0, value} | 64'd1;
            r = 64'd1 % modulus;
            for (int i = 0; i < 2 * RED_STEPS; i++) begin
                r = r << 1;
                if (r >= modulus) r = r - modulus;
            end
            r_sq = r;
        endfunction

        // bit-serial montgomery reduction, unnormalized
        function bit [63:0] reduce(bit [63:0] a);
            for (int i = 0; i < RED_STEPS; i++) begin
                if (a[0]) a = a + modulus;
                a = a >> 1;
            end
            return a;
        endfunction

        function bit [63:0] into_mont(bit [63:0] raw);
            bit [63:0] mag, rem, base;
            mag  = raw[63] ? (~raw + 64'd1) : raw;
            rem  = mag % modulus;
            base = raw[63] ? (modulus - rem) : (rem + modulus);
            return reduce(base * r_sq) & MASK31;
        endfunction

        function bit [63:0] mont_mul(bit [63:0] a, bit [63:0] b);
            return reduce((a & MASK31) * (b & MASK31)) & MASK31;
        endfunction

        function bit [63:0] out_of_mont(bit [63:0] a);
            bit [63:0] x;
            x = reduce(a & MASK31);
            return (x >= modulus ? x - modulus : x) & MASK31;
        endfunction

        // extended euclid on the plain residue, result back in montgomery form
        function bit [63:0] mont_inverse(bit [63:0] a);
            longint x, y, u, v, q, tmp;
            x = out_of_mont(a);
            y = modulus;
            u = 1;
            v = 0;
            while (y != 0) begin
                q = x / y;
                x = x - y * q;
                u = u - v * q;
                tmp = x; x = y; y = tmp;
                tmp = u; u = v; v = tmp;
            end
            return into_mont(u);
        endfunction

        function bit [63:0] mont_power(bit [63:0] a, bit [63:0] raw_exp);
            bit [63:0] e, acc, base;
            e    = raw_exp[63] ? (~raw_exp + 64'd1) : raw_exp;
            acc  = into_mont(64'd1);
            base = a & MASK31;
            while (e != 0) begin
                if (e[0]) acc = mont_mul(acc, base);
                base = mont_mul(base, base);
                e = e >> 1;
            end
            return raw_exp[63] ? mont_inverse(acc) : acc;
        endfunction

        function t_mma_out predict_item(t_mma_in beat);
            t_mma_out  r;
            bit [63:0] a, b, m2, ra, rb, s;
            a  = 64'(beat.op_a);
            b  = 64'(beat.op_b);
            m2 = 2 * modulus;
            r  = '0;
            case (beat.cmd)
                CMD_TO_MONT:   r.result = 31'(into_mont(beat.plain_value));
                CMD_FROM_MONT: r.result = 31'(out_of_mont(a));
                CMD_ADD: begin
                    s = a + b;
                    r.result = 31'((s >= m2) ? s - m2 : s);
                end
                CMD_SUB:       r.result = 31'((a >= b) ? a - b : a + m2 - b);
                CMD_MUL:       r.result = 31'(mont_mul(a, b));
                CMD_POW:       r.result = 31'(mont_power(a, beat.exponent));
                CMD_INV:       r.result = 31'(mont_inverse(a));
                default: begin
                    ra = (a >= modulus) ? a - modulus : a;
                    rb = (b >= modulus) ? b - modulus : b;
                    r.is_equal = (ra == rb);
                end
            endcase
            return r;
        endfunction

        function void note_operand(t_mma_in beat);
            pending.push_back(predict_item(beat));
        endfunction

        function void check_result(t_mma_out got);
            t_mma_out want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result || got.is_equal !== want.is_equal) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: result exp %h got %h, is_equal exp %b got %b",
                             checked, want.result, got.result, want.is_equal, got.is_equal);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic [MMA_MOD_BITS-1:0] i_cfg_wdata;
    logic     i_in_valid;
    logic     o_in_ready;
    t_mma_in  i_in;
    logic     o_out_valid;
    logic     i_out_ready;
    t_mma_out o_out;

    mont_scoreboard sb = new();
    int  idle_cycles;
    int  items_sent;
    int  results_seen;
    bit  hold_done;
    bit  [7:0] cmd_hits;

    montgomery_modular_alu_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // signed value of random width, full width now and then
    function automatic bit [63:0] rand_signed();
        bit [63:0] v;
        int        w;
        w = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 40);
        v = rand64();
        if (w < 64) v = v & ((64'd1 << w) - 1);
        if ($urandom_range(0, 1)) v = ~v + 64'd1;
        return v;
    endfunction

    // operand mostly in the lazy range, sometimes any 31-bit value
    function automatic logic [30:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 31'($urandom);
            1:       return 31'(2 * sb.modulus - 1);
            2:       return 31'($urandom_range(0, 3));
            default: return 31'($urandom % (2 * sb.modulus));
        endcase
    endfunction

    function automatic t_mma_in rand_item();
        t_mma_in it;
        it.cmd         = t_mma_cmd'($urandom_range(0, 7));
        it.op_a        = rand_operand();
        it.op_b        = ($urandom_range(0, 5) == 0) ? it.op_a : rand_operand();
        it.plain_value = rand_signed();
        // exponents mostly short to keep power commands quick
        if ($urandom_range(0, 29) == 0) it.exponent = rand64();
        else begin
            it.exponent = 64'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0) it.exponent = -it.exponent;
        end
        return it;
    endfunction

    function automatic t_mma_in mk(t_mma_cmd c, logic [30:0] a, logic [30:0] b,
                                   logic [63:0] e, logic [63:0] p);
        t_mma_in it;
        it.cmd = c; it.op_a = a; it.op_b = b; it.exponent = e; it.plain_value = p;
        return it;
    endfunction

    // offer one beat and hold it until accepted, then maybe idle
    task automatic send_item(t_mma_in it, bit no_gap);
        int gap;
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_operand(it);
        items_sent++;
        cmd_hits[it.cmd] = 1'b1;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // modulus write only once everything in flight has come back
    task automatic write_modulus(logic [MMA_MOD_BITS-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_modulus(value);
    endtask

    task automatic random_phase(int n);
        bit burst;
        for (int i = 0; i < n; i++) begin
            burst = (i / 20) % 3 == 1;
            send_item(rand_item(), burst);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out);
                results_seen++;
            end
            if (!hold_done && results_seen == 120) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (pick_gap() > 0 && $urandom_range(0, 1)) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [30:0] m2;
        int wait_left;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases under the reset modulus
        m2 = 31'(2 * sb.modulus);
        send_item(mk(CMD_TO_MONT, 0, 0, 0, 64'd0), 0);
        send_item(mk(CMD_TO_MONT, 0, 0, 0, 64'd1), 0);
        send_item(mk(CMD_TO_MONT, 0, 0, 0, -64'sd1), 0);
        send_item(mk(CMD_TO_MONT, 0, 0, 0, 64'h7fffffffffffffff), 0);
        send_item(mk(CMD_TO_MONT, 0, 0, 0, 64'h8000000000000000), 0);
        send_item(mk(CMD_FROM_MONT, 0, 0, 0, 0), 0);
        send_item(mk(CMD_FROM_MONT, m2 - 1, 0, 0, 0), 0);
        send_item(mk(CMD_FROM_MONT, MASK31, 0, 0, 0), 0);
        send_item(mk(CMD_ADD, m2 - 1, m2 - 1, 0, 0), 0);
        send_item(mk(CMD_ADD, MASK31, MASK31, 0, 0), 0);
        send_item(mk(CMD_SUB, 0, m2 - 1, 0, 0), 0);
        send_item(mk(CMD_SUB, 5, MASK31, 0, 0), 0);
        send_item(mk(CMD_MUL, MASK31, MASK31, 0, 0), 0);
        send_item(mk(CMD_MUL, 0, m2 - 1, 0, 0), 0);
        send_item(mk(CMD_POW, 12345, 0, 64'd0, 0), 0);
        send_item(mk(CMD_POW, 12345, 0, 64'd1, 0), 0);
        send_item(mk(CMD_POW, 12345, 0, -64'sd1, 0), 0);
        send_item(mk(CMD_POW, 777, 0, 64'h8000000000000000, 0), 0);
        send_item(mk(CMD_POW, MASK31, 0, 64'h7fffffffffffffff, 0), 0);
        send_item(mk(CMD_INV, 0, 0, 0, 0), 0);
        send_item(mk(CMD_INV, 31'(sb.into_mont(64'd1)), 0, 0, 0), 0);
        send_item(mk(CMD_INV, m2 - 1, 0, 0, 0), 0);
        send_item(mk(CMD_EQUAL, 17, 31'(17 + sb.modulus), 0, 0), 0);
        send_item(mk(CMD_EQUAL, 17, 18, 0, 0), 0);
        send_item(mk(CMD_EQUAL, MASK31, MASK31, 0, 0), 0);

        // random phases over several moduli, extremes included
        random_phase(PHASE_LEN);
        write_modulus(30'd3);
        random_phase(PHASE_LEN);
        write_modulus(30'h3fffffff);
        random_phase(PHASE_LEN);
        write_modulus(30'd1000000006);   // even value, low bit forced
        random_phase(PHASE_LEN);
        write_modulus(30'd0);            // degenerate modulus of one
        random_phase(40);
        write_modulus(30'd2);
        random_phase(40);
        write_modulus(30'($urandom | 1));
        random_phase(PHASE_LEN);
        write_modulus(30'd1000000007);
        random_phase(PHASE_LEN);
        write_modulus(MMA_RESET_MODULUS);
        random_phase(PHASE_LEN);

        // wait for the tail, bounded
        i_in_valid <= 1'b0;
        wait_left = IDLE_LIMIT;
        while (sb.pending.size() > 0 && wait_left > 0) begin
            @(posedge i_clk);
            wait_left--;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items over 9 modulus settings, command mask %b",
                 items_sent, cmd_hits);
        $display("%0d results checked, %0d mismatches, %0d outstanding",
                 sb.checked, sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/mma_pkg.sv
sv/mma_div.sv
sv/mma_redc.sv
sv/montgomery_modular_alu_core.sv
sv/mma_checker.sv
tb/sv/tb.sv
